[design/bbc_pkg.sv]
// Shared constants and types for the bracket balance checker.
package bbc_pkg;

    localparam int STACK_DEPTH = 1024;
    localparam int FILL_W      = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int COUNT_W     = 16;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;
    localparam int OUT_USED_W  = COUNT_W + 1;

    localparam logic [7:0] CH_OPEN_ROUND   = 8'h28;
    localparam logic [7:0] CH_CLOSE_ROUND  = 8'h29;
    localparam logic [7:0] CH_OPEN_SQUARE  = 8'h5B;
    localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D;
    localparam logic [7:0] CH_OPEN_CURLY   = 8'h7B;
    localparam logic [7:0] CH_CLOSE_CURLY  = 8'h7D;

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_ROUND  = 2'd1,
        KIND_SQUARE = 2'd2,
        KIND_CURLY  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_OPEN  = 2'd1,
        OP_CLOSE = 2'd2
    } t_op;

    typedef struct packed {
        t_op   op;
        t_kind kind;
        logic  last;
    } t_item;

endpackage

[design/bbc_front.sv]
// Front end: takes input bytes and turns each into a classified stack operation.
module bbc_front
    import bbc_pkg::*;
(
    input  logic                  i_in_valid,
    input  logic [IN_TDATA_W-1:0] i_in_char,
    input  logic                  i_in_last,
    output logic                  o_in_ready,
    input  logic                  i_queue_full,
    output logic                  o_push,
    output t_item                 o_push_item
);

    function automatic t_item classify(input logic [7:0] c, input logic last);
        t_item it;
        it.last = last;
        case (c)
            CH_OPEN_ROUND:   begin it.op = OP_OPEN;  it.kind = KIND_ROUND;  end
            CH_OPEN_SQUARE:  begin it.op = OP_OPEN;  it.kind = KIND_SQUARE; end
            CH_OPEN_CURLY:   begin it.op = OP_OPEN;  it.kind = KIND_CURLY;  end
            CH_CLOSE_ROUND:  begin it.op = OP_CLOSE; it.kind = KIND_ROUND;  end
            CH_CLOSE_SQUARE: begin it.op = OP_CLOSE; it.kind = KIND_SQUARE; end
            CH_CLOSE_CURLY:  begin it.op = OP_CLOSE; it.kind = KIND_CURLY;  end
            default:         begin it.op = OP_NONE;  it.kind = KIND_NONE;   end
        endcase
        return it;
    endfunction

    assign o_in_ready  = !i_queue_full;
    assign o_push      = i_in_valid && !i_queue_full;
    assign o_push_item = classify(i_in_char, i_in_last);

endmodule

[design/bbc_queue.sv]
// Short queue of classified operations between the front and back ends.
module bbc_queue
    import bbc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_push_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_item
);

    t_item             r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_slot[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? ptr_inc(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = i_pop  ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_push_item;
        end
    end

endmodule

[design/bbc_back.sv]
// Back end: bracket stack with a cached top entry, counters and the result register.
module bbc_back
    import bbc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_item_valid,
    input  t_item              i_item,
    output logic               o_item_take,
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output logic               o_res_balanced,
    output logic [COUNT_W-1:0] o_res_count
);

    // The top entry lives in r_top; the memory holds the entries beneath it.
    t_kind              r_mem [STACK_DEPTH];
    t_kind              r_mem_q;
    t_kind              r_top, n_top;
    logic               r_byp, n_byp;
    t_kind              r_byp_kind;
    logic [FILL_W-1:0]  r_fill, n_fill, s_fill;
    logic               r_mis, n_mis, s_mis;
    logic [COUNT_W-1:0] r_cnt, n_cnt, s_cnt;
    logic               r_res_valid, n_res_valid;
    logic               r_res_bal;
    logic [COUNT_W-1:0] r_res_cnt;
    logic               take, res_load;
    logic               we;
    logic [FILL_W-1:0]  fill_m1, nfill_m2;
    logic [ADDR_W-1:0]  wa, ra;
    t_kind              under;

    assign take     = i_item_valid && (!i_item.last || !r_res_valid || i_res_ready);
    assign res_load = take && i_item.last;
    assign under    = r_byp ? r_byp_kind : r_mem_q;
    assign fill_m1  = r_fill - FILL_W'(1);
    assign wa       = fill_m1[ADDR_W-1:0];

    always_comb begin
        s_fill = r_fill;
        s_mis  = r_mis;
        s_cnt  = r_cnt;
        n_top  = r_top;
        we     = 1'b0;
        if (take) begin
            case (i_item.op)
                OP_OPEN: begin
                    // A push onto a full stack is dropped but still counted.
                    if (r_fill != FILL_W'(STACK_DEPTH)) begin
                        we     = (r_fill != '0);
                        n_top  = i_item.kind;
                        s_fill = r_fill + FILL_W'(1);
                    end
                    if (r_cnt != '1) s_cnt = r_cnt + COUNT_W'(1);
                end
                OP_CLOSE: begin
                    if (r_fill != '0 && r_top == i_item.kind) begin
                        s_fill = fill_m1;
                        n_top  = under;
                    end else begin
                        s_mis = 1'b1;
                    end
                    if (r_cnt != '1) s_cnt = r_cnt + COUNT_W'(1);
                end
                default: begin
                end
            endcase
        end
        n_fill = s_fill;
        n_mis  = s_mis;
        n_cnt  = s_cnt;
        if (res_load) begin
            n_fill = '0;
            n_mis  = 1'b0;
            n_cnt  = '0;
        end
    end

    // Always prefetch the entry that will sit just under the new top.
    assign nfill_m2 = n_fill - FILL_W'(2);
    assign ra       = nfill_m2[ADDR_W-1:0];
    assign n_byp    = we && (wa == ra);

    assign n_res_valid = (r_res_valid && !i_res_ready) || res_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_mis       <= 1'b0;
            r_cnt       <= '0;
            r_byp       <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_fill      <= n_fill;
            r_mis       <= n_mis;
            r_cnt       <= n_cnt;
            r_byp       <= n_byp;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top      <= n_top;
        r_byp_kind <= r_top;
        if (res_load) begin
            r_res_bal <= !s_mis && (s_fill == '0);
            r_res_cnt <= s_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= r_top;
        end
        r_mem_q <= r_mem[ra];
    end

    assign o_item_take    = take;
    assign o_res_valid    = r_res_valid;
    assign o_res_balanced = r_res_bal;
    assign o_res_count    = r_res_cnt;

endmodule

[design/bracket_balance_checker_core.sv]
// Top level of the bracket balance checker.
//
//  Channel   Direction  Payload (low bit first)                 Per transfer
//  s_axis    in         tdata: char_code[7:0]; tlast: last_char  one byte of a string
//  m_axis    out        tdata: balanced, bracket_count, zeros    one result per string
//
// One byte is taken every cycle while tready is high; the stack keeps its top entry in a
// register and prefetches the entry beneath it from the memory, so pushes and pops never
// stall. tvalid rises once a string's last byte has passed the queue and result register.
// Reset clears the fill count and the flags; the stack memory is not cleared, as the
// fill count marks which entries are live.
// While a result waits, later non-final bytes still flow; a second final byte waits
// in the two-entry queue, and tready falls only when that queue is full.
module bracket_balance_checker_core
    import bbc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,  // char_code[7:0]
    input  logic                   i_s_axis_tlast,  // last_char
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata   // balanced[0], bracket_count[16:1], zero
);

    logic               push, queue_full, queue_valid, item_take;
    t_item              push_item, queue_item;
    logic               res_balanced;
    logic [COUNT_W-1:0] res_count;

    bbc_front u_front (
        .i_in_valid   (i_s_axis_tvalid),
        .i_in_char    (i_s_axis_tdata),
        .i_in_last    (i_s_axis_tlast),
        .o_in_ready   (o_s_axis_tready),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_push_item  (push_item)
    );

    bbc_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_item (push_item),
        .o_full      (queue_full),
        .i_pop       (item_take),
        .o_valid     (queue_valid),
        .o_item      (queue_item)
    );

    bbc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item_valid   (queue_valid),
        .i_item         (queue_item),
        .o_item_take    (item_take),
        .o_res_valid    (o_m_axis_tvalid),
        .i_res_ready    (i_m_axis_tready),
        .o_res_balanced (res_balanced),
        .o_res_count    (res_count)
    );

    assign o_m_axis_tdata = {(OUT_TDATA_W - OUT_USED_W)'(0), res_count, res_balanced};

endmodule

[design/bbc_checker.sv]
// Port-level assertions for the bracket balance checker, bound to the top level.
module bbc_checker
    import bbc_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_s_axis_tready,
    input logic                   o_m_axis_tvalid,
    input logic                   i_m_axis_tready,
    input logic [OUT_TDATA_W-1:0] o_m_axis_tdata
);

    // A stalled result keeps its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    // A string without brackets is always balanced.
    a_empty_balanced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tdata[16:1] == '0) |-> o_m_axis_tdata[0])
        else $error("string with no brackets reported unbalanced");

    // The input side is open straight after reset.
    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> o_s_axis_tready)
        else $error("input not ready straight after reset");

    // No result is pending after reset.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid straight after reset");

endmodule

bind bracket_balance_checker_core bbc_checker u_bbc_checker (.*);
